// ----- rtl/wnfd_pkg.sv -----
// shared constants and types for the window nearest frame distance unit
package wnfd_pkg;

    localparam int DEF_MAX_FRAMES  = 16;
    localparam int DEF_MAX_LEN     = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int DIST_W = 40;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOKBACK  = 2'd0,
        CFG_LOOKAHEAD = 2'd1,
        CFG_FRAME_LEN = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAIR = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

// ----- rtl/wnfd_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module wnfd_div #(
    parameter int NW = 45,
    parameter int DW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW:0]   r2;
    logic          ge;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        r2        = {r_reg, q_reg[NW-1]};
        ge        = (r2 >= {1'b0, divisor});
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            q_next   = dividend;
            r_next   = '0;
        end
        else if (run_reg)
        begin
            r_next = ge ? DW'(r2 - {1'b0, divisor}) : DW'(r2);
            if (NW > 1)
                q_next = {q_reg[NW-2:0], ge};
            else
                q_next = NW'(ge);
            cnt_next = cnt_reg + 1'b1;
            if (32'(cnt_reg) == NW - 1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/window_nearest_frame_distance_unit.sv -----
// top level: windowed nearest frame distance over a sample stream
// each sample beat runs accept, win pair reads over one port, a two stage pipe and close
// a frame end with a full window adds a min scan over the pair memory, a serial division
// and a load of the output register
// reset clears control state and config to lookback 2, lookahead 2, frame_len 64;
// the sample and pair memories are not cleared and need no clearing pass
module window_nearest_frame_distance_unit #(
    parameter int MAX_FRAMES  = wnfd_pkg::DEF_MAX_FRAMES,
    parameter int MAX_LEN     = wnfd_pkg::DEF_MAX_LEN,
    parameter int SAMPLE_BITS = wnfd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wnfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wnfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wnfd_pkg::DIST_W-1:0]       mean_min_dist,
    output logic                              warming
);

    import wnfd_pkg::*;

    localparam int SW   = $clog2(MAX_FRAMES);
    localparam int FW   = $clog2(MAX_FRAMES + 1);
    localparam int PW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW   = $clog2(MAX_LEN + 1);
    localparam int FAW  = $clog2(MAX_FRAMES * MAX_LEN);
    localparam int PAW  = $clog2(MAX_FRAMES * MAX_FRAMES);
    localparam int DSW  = SAMPLE_BITS + 1;
    localparam int SQW  = 2 * DSW;
    localparam int ACCW = ((SQW > DIST_W) ? SQW : DIST_W) + 1;
    localparam int SUMW = DIST_W + FW;

    // memories
    logic signed [SAMPLE_BITS-1:0] fs_mem [MAX_FRAMES*MAX_LEN];
    logic [DIST_W-1:0]             pd_mem [MAX_FRAMES*MAX_FRAMES];
    logic signed [SAMPLE_BITS-1:0] fs_rdata_reg;
    logic [DIST_W-1:0]             pd_rdata_reg;
    logic                          fs_we, pd_we;
    logic [FAW-1:0]                fs_waddr, fs_raddr;
    logic [PAW-1:0]                pd_waddr, pd_raddr;
    logic [DIST_W-1:0]             pd_wdata;

    // config and stream state
    logic [2:0]        lookback_reg, lookback_next;
    logic [3:0]        lookahead_reg, lookahead_next;
    logic [8:0]        frame_len_reg, frame_len_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [FW-1:0]     seen_reg, seen_next;
    state_t            state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;

    // pair pipe
    logic [FW-1:0]     cnt_reg, cnt_next;
    logic              v1_reg, v1_next, v2_reg, v2_next;
    logic [SW-1:0]     t1_reg, t1_next, t2_reg, t2_next;
    logic [SQW-1:0]    sq_reg, sq_next;
    logic [DIST_W-1:0] pdh_reg, pdh_next;

    // scan
    logic              scan_run_reg, scan_run_next;
    logic [SW-1:0]     i_reg, i_next, j_reg, j_next;
    logic              s1_issue_reg, s1_issue_next;
    logic              s1_v_reg, s1_v_next;
    logic              s1_last_reg, s1_last_next;
    logic              s1_done_reg, s1_done_next;
    logic [DIST_W-1:0] min_reg, min_next;
    logic [SUMW-1:0]   sum_reg, sum_next;

    // result and output
    logic [DIST_W-1:0] res_mean_reg, res_mean_next;
    logic              res_warm_reg, res_warm_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] out_mean_reg, out_mean_next;
    logic              out_warm_reg, out_warm_next;

    // effective config
    logic [FW-1:0]     lb_eff, la_eff, win;
    logic [LW-1:0]     len_eff;
    int                room;

    logic              issue, pair_done, row_last;
    logic [SW-1:0]     t_issue;
    logic [FW-1:0]     seen_inc;
    logic signed [DSW-1:0] d;
    logic signed [SQW-1:0] sq_full;
    logic [ACCW-1:0]   acc;
    logic [DIST_W-1:0] m_new;
    logic              div_start, div_done;
    logic [SUMW-1:0]   div_quot;

    function automatic logic [PAW-1:0] pair_addr(input logic [SW-1:0] a,
                                                  input logic [SW-1:0] b);
        logic [SW-1:0] lo;
        logic [SW-1:0] hi;
        if (a < b)
        begin
            lo = a;
            hi = b;
        end
        else
        begin
            lo = b;
            hi = a;
        end
        return PAW'(32'(lo) * MAX_FRAMES + 32'(hi));
    endfunction

    always_comb
    begin
        if (32'(lookback_reg) > MAX_FRAMES - 1)
            lb_eff = FW'(MAX_FRAMES - 1);
        else
            lb_eff = FW'(lookback_reg);
        room = MAX_FRAMES - 1 - 32'(lb_eff);
        if (32'(lookahead_reg) > room)
            la_eff = FW'(room);
        else
            la_eff = FW'(lookahead_reg);
        win = FW'(32'(lb_eff) + 32'(la_eff) + 1);
        if (frame_len_reg == '0)
            len_eff = LW'(1);
        else if (32'(frame_len_reg) > MAX_LEN)
            len_eff = LW'(MAX_LEN);
        else
            len_eff = LW'(frame_len_reg);
    end

    wnfd_div #(
        .NW (SUMW),
        .DW (FW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (win),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        lookback_next  = lookback_reg;
        lookahead_next = lookahead_reg;
        frame_len_next = frame_len_reg;
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        seen_next      = seen_reg;
        state_next     = state_reg;
        x_next         = x_reg;
        cnt_next       = cnt_reg;
        scan_run_next  = scan_run_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        min_next       = min_reg;
        sum_next       = sum_reg;
        res_mean_next  = res_mean_reg;
        res_warm_next  = res_warm_reg;
        out_mean_next  = out_mean_reg;
        out_warm_next  = out_warm_reg;
        out_valid_next = out_valid_reg;
        fs_we          = 1'b0;
        fs_waddr       = FAW'(32'(slot_reg) * MAX_LEN + 32'(pos_reg));
        div_start      = 1'b0;
        issue          = 1'b0;
        t_issue        = cnt_reg[SW-1:0];
        s1_issue_next  = 1'b0;
        s1_v_next      = 1'b0;
        s1_last_next   = 1'b0;
        s1_done_next   = 1'b0;
        row_last       = (32'(j_reg) + 1 == 32'(win));
        pair_done      = (cnt_reg == win) && !v1_reg && !v2_reg;
        seen_inc       = (seen_reg < win) ? seen_reg + 1'b1 : seen_reg;

        // pair pipe stages
        d        = DSW'(x_reg) - DSW'(fs_rdata_reg);
        sq_full  = d * d;
        sq_next  = unsigned'(sq_full);
        pdh_next = pd_rdata_reg;
        v2_next  = v1_reg;
        t2_next  = t1_reg;
        acc      = ((pos_reg == '0) ? ACCW'(0) : ACCW'(pdh_reg)) + ACCW'(sq_reg);
        pd_we    = v2_reg;
        pd_waddr = pair_addr(slot_reg, t2_reg);
        pd_wdata = (acc > ACCW'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];

        // min scan stage
        m_new = (s1_v_reg && (pd_rdata_reg < min_reg)) ? pd_rdata_reg : min_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample;
                    fs_we      = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                if (cnt_reg < win)
                begin
                    issue    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pair_done)
                begin
                    if (32'(pos_reg) + 1 < 32'(len_eff))
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next  = '0;
                        slot_next = (32'(slot_reg) + 1 >= 32'(win)) ? '0 : slot_reg + 1'b1;
                        seen_next = seen_inc;
                        if (32'(seen_inc) < 32'(la_eff) + 1)
                            state_next = ST_IDLE;
                        else if (seen_inc < win)
                        begin
                            res_mean_next = '0;
                            res_warm_next = 1'b1;
                            state_next    = ST_OUT;
                        end
                        else
                        begin
                            scan_run_next = 1'b1;
                            i_next        = '0;
                            j_next        = '0;
                            min_next      = DIST_MAX;
                            sum_next      = '0;
                            state_next    = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_run_reg)
                begin
                    s1_issue_next = 1'b1;
                    s1_v_next     = (i_reg != j_reg);
                    s1_last_next  = row_last;
                    s1_done_next  = row_last && (32'(i_reg) + 1 == 32'(win));
                    if (row_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                        if (32'(i_reg) + 1 == 32'(win))
                            scan_run_next = 1'b0;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
                if (s1_issue_reg)
                begin
                    if (s1_last_reg)
                    begin
                        sum_next = sum_reg + SUMW'(m_new);
                        min_next = DIST_MAX;
                    end
                    else
                        min_next = m_new;
                    if (s1_done_reg)
                        state_next = ST_DIV;
                end
                if (s1_done_reg)
                    div_start = 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_mean_next = div_quot[DIST_W-1:0];
                    res_warm_next = 1'b0;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = res_mean_reg;
                    out_warm_next  = res_warm_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        v1_next  = issue && (t_issue != slot_reg);
        t1_next  = t_issue;
        fs_raddr = FAW'(32'(t_issue) * MAX_LEN + 32'(pos_reg));
        pd_raddr = (state_reg == ST_PAIR) ? pair_addr(slot_reg, t_issue)
                                          : pair_addr(i_reg, j_reg);

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOOKBACK:
                begin
                    lookback_next = cfg_data[2:0];
                    pos_next      = '0;
                    slot_next     = '0;
                    seen_next     = '0;
                end
                CFG_LOOKAHEAD:
                begin
                    lookahead_next = cfg_data[3:0];
                    pos_next       = '0;
                    slot_next      = '0;
                    seen_next      = '0;
                end
                CFG_FRAME_LEN:
                begin
                    frame_len_next = cfg_data[8:0];
                    pos_next       = '0;
                    slot_next      = '0;
                    seen_next      = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
            fs_mem[fs_waddr] <= sample;
        fs_rdata_reg <= fs_mem[fs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pd_we)
            pd_mem[pd_waddr] <= pd_wdata;
        pd_rdata_reg <= pd_mem[pd_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookback_reg  <= 3'd2;
            lookahead_reg <= 4'd2;
            frame_len_reg <= 9'd64;
            pos_reg       <= '0;
            slot_reg      <= '0;
            seen_reg      <= '0;
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            scan_run_reg  <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            s1_issue_reg  <= 1'b0;
            s1_v_reg      <= 1'b0;
            s1_last_reg   <= 1'b0;
            s1_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lookback_reg  <= lookback_next;
            lookahead_reg <= lookahead_next;
            frame_len_reg <= frame_len_next;
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
            seen_reg      <= seen_next;
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            scan_run_reg  <= scan_run_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            s1_issue_reg  <= s1_issue_next;
            s1_v_reg      <= s1_v_next;
            s1_last_reg   <= s1_last_next;
            s1_done_reg   <= s1_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        sq_reg       <= sq_next;
        pdh_reg      <= pdh_next;
        min_reg      <= min_next;
        sum_reg      <= sum_next;
        res_mean_reg <= res_mean_next;
        res_warm_reg <= res_warm_next;
        out_mean_reg <= out_mean_next;
        out_warm_reg <= out_warm_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign mean_min_dist = out_mean_reg;
    assign warming       = out_warm_reg;

`ifndef SYNTH
    a_warm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && warming |-> mean_min_dist == '0)
        else $error("warming beat with nonzero distance");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= win)
        else $error("frame count beyond window");

    a_no_self_pair: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> t2_reg != slot_reg)
        else $error("pair update on own slot");

    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output beat raised outside load state");
`endif

endmodule

// ----- bench/tb_window_nearest_frame_distance_unit.sv -----
// testbench for the window nearest frame distance unit, self-checking against a frame window model
module tb_window_nearest_frame_distance_unit;
    import wnfd_pkg::*;

    localparam int MAX_FRAMES = 16;
    localparam int MAX_LEN = 256;
    localparam int RANDOM_ITEMS = 1400;
    localparam int SETTLE_CYCLES = 400;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic [DIST_W-1:0] mean;
        logic              warm;
    } window_result_t;

    class window_scoreboard;
        logic signed [15:0] frame_mem[MAX_FRAMES][MAX_LEN];
        logic [DIST_W-1:0]  pair_mem[MAX_FRAMES][MAX_FRAMES];
        int unsigned        position;
        int unsigned        slot;
        int unsigned        frames;
        int unsigned        lookback_reg;
        int unsigned        lookahead_reg;
        int unsigned        frame_len_reg;
        window_result_t     expected_q[$];
        int                 errors;
        int                 checked;
        int                 warm_seen;
        int                 sat_seen;

        function new();
            foreach (frame_mem[i, j]) frame_mem[i][j] = '0;
            foreach (pair_mem[i, j]) pair_mem[i][j] = '0;
            lookback_reg = 2;
            lookahead_reg = 2;
            frame_len_reg = 64;
            position = 0;
            slot = 0;
            frames = 0;
            errors = 0;
            checked = 0;
            warm_seen = 0;
            sat_seen = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LOOKBACK:  lookback_reg = value[2:0];
                CFG_LOOKAHEAD: lookahead_reg = value[3:0];
                CFG_FRAME_LEN: frame_len_reg = value[8:0];
                default: return;
            endcase
            position = 0;
            slot = 0;
            frames = 0;
        endfunction

        function int unsigned window_size();
            int unsigned lb;
            int unsigned la;
            lb = (lookback_reg > MAX_FRAMES - 1) ? MAX_FRAMES - 1 : lookback_reg;
            la = (lookahead_reg > MAX_FRAMES - 1 - lb) ? MAX_FRAMES - 1 - lb : lookahead_reg;
            return lb + la + 1;
        endfunction

        function void note_sample(logic signed [15:0] x);
            int unsigned lb;
            int unsigned la;
            int unsigned win;
            int unsigned len;
            int unsigned s;
            int unsigned p;
            longint d;
            longint unsigned acc;
            longint unsigned sum;
            logic [DIST_W-1:0] m;
            window_result_t r;
            lb = (lookback_reg > MAX_FRAMES - 1) ? MAX_FRAMES - 1 : lookback_reg;
            la = (lookahead_reg > MAX_FRAMES - 1 - lb) ? MAX_FRAMES - 1 - lb : lookahead_reg;
            win = lb + la + 1;
            len = (frame_len_reg == 0) ? 1 : (frame_len_reg > MAX_LEN ? MAX_LEN : frame_len_reg);
            s = (slot >= win) ? 0 : slot;
            p = (position >= len) ? 0 : position;
            frame_mem[s][p] = x;
            for (int t = 0; t < win; t++) begin
                if (t == s) continue;
                d = longint'(x) - longint'(frame_mem[t][p]);
                acc = (p == 0) ? 0 : longint'(pair_mem[s][t]);
                acc += longint'(d * d);
                if (acc > longint'(DIST_MAX)) acc = longint'(DIST_MAX);
                pair_mem[s][t] = acc[DIST_W-1:0];
                pair_mem[t][s] = acc[DIST_W-1:0];
            end
            p++;
            if (p < len) begin
                position = p;
                slot = s;
                return;
            end
            position = 0;
            slot = (s + 1 >= win) ? 0 : s + 1;
            if (frames < win) frames++;
            if (frames < la + 1) return;
            if (frames < win) begin
                r.mean = '0;
                r.warm = 1'b1;
                expected_q.push_back(r);
                return;
            end
            sum = 0;
            for (int i = 0; i < win; i++) begin
                m = DIST_MAX;
                for (int j = 0; j < win; j++)
                    if (j != i && pair_mem[i][j] < m) m = pair_mem[i][j];
                sum += m;
            end
            sum = sum / win;
            r.mean = sum[DIST_W-1:0];
            r.warm = 1'b0;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("mismatch @%0t: %s", $time, msg);
        endtask

        task check_result(logic [DIST_W-1:0] mean, logic warm);
            window_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result mean=%0d warming=%0b", mean, warm));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (warm) warm_seen++;
            if (mean == DIST_MAX) sat_seen++;
            if (mean !== e.mean)
                report($sformatf("result %0d: mean_min_dist %0d, want %0d", checked, mean, e.mean));
            if (warm !== e.warm)
                report($sformatf("result %0d: warming %0b, want %0b", checked, warm, e.warm));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOOKBACK;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic signed [15:0]    sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DIST_W-1:0]     mean_min_dist;
    logic                  warming;

    window_scoreboard sb = new();
    int items_sent = 0;
    int phases = 0;
    int burst_left = 0;

    window_nearest_frame_distance_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .mean_min_dist(mean_min_dist), .warming(warming)
    );

    always #5 clk = ~clk;

    // receiver stall pattern: free, random, long holds
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(mean_min_dist, warming);
    end

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic configure(int lb, int la, int len);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_LOOKBACK, CFG_DATA_W'(lb));
        write_register(CFG_LOOKAHEAD, CFG_DATA_W'(la));
        write_register(CFG_FRAME_LEN, CFG_DATA_W'(len));
        cfg_we <= 1'b0;
        phases++;
    endtask

    // one beat, with random bursts and gaps ahead of it
    task automatic send_sample(logic signed [15:0] x);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        sample <= x;
        do @(posedge clk); while (in_stall);
        sb.note_sample(x);
        items_sent++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic signed [15:0] pick_sample(int kind, logic signed [15:0] base);
        case (kind)
            0: return 16'($urandom());
            1: return base + $signed(16'($urandom_range(0, 8))) - 16'sd4;
            default: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    initial begin
        int lb;
        int la;
        int len;
        int win;
        int count;
        int kind;
        int start;
        logic signed [15:0] base;
        logic sat_run;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-frame window, single-sample frames
        configure(0, 0, 1);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        stop_sending();
        // oversized window and zero frame length
        configure(7, 15, 0);
        for (int i = 0; i < 20; i++)
            send_sample(i % 3 == 0 ? 16'sh8000 : (i % 3 == 1 ? 16'sh7fff : 16'sh0001 << (i % 16)));
        stop_sending();

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            sat_run = 1'b0;
            lb = $urandom_range(0, 7);
            la = $urandom_range(0, 15);
            case ($urandom_range(0, 24))
                0: begin
                    lb = 1;
                    la = 0;
                    len = ($urandom_range(0, 1) != 0) ? 256 : 511;
                    sat_run = 1'b1;
                end
                1: len = 300;
                2: len = 0;
                3, 4, 5: len = $urandom_range(7, 64);
                default: len = $urandom_range(1, 6);
            endcase
            configure(lb, la, len);
            win = sb.window_size();
            len = (len == 0) ? 1 : (len > MAX_LEN ? MAX_LEN : len);
            count = len * (sat_run ? 3 : win + $urandom_range(1, 4)) + $urandom_range(0, len - 1);
            if (count > RANDOM_ITEMS - (items_sent - start))
                count = RANDOM_ITEMS - (items_sent - start);
            kind = $urandom_range(0, 2);
            base = 16'($urandom());
            for (int i = 0; i < count; i++) begin
                if (i == count / 2 && $urandom_range(0, 3) == 0) begin
                    stop_sending();
                    wait_drained();
                    @(posedge clk);
                end
                if (i % len == 0 && kind == 1) base = 16'($urandom());
                if (sat_run)
                    send_sample(((i / len) % 2 != 0) ? 16'sh7fff : 16'sh8000);
                else
                    send_sample(pick_sample(kind, base));
            end
            stop_sending();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        $display("%0d beats over %0d register settings, %0d results checked",
                 items_sent, phases, sb.checked);
        $display("%0d warming results, %0d saturated results", sb.warm_seen, sb.sat_seen);
        if (sb.errors == 0)
            $display("** window_nearest_frame_distance_unit: PASSED **");
        else
            $display("** window_nearest_frame_distance_unit: FAILED **");
        $finish;
    end

    initial begin
        #60000000;
        $display("timeout waiting for the block");
        $display("** window_nearest_frame_distance_unit: FAILED **");
        $finish;
    end

endmodule
